// File: rtl/epoch_calendar_converter_assert.svh
// ----------------------------------------------------------------------------
// Epoch calendar converter assertion macros
// Shared property forms for the converter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef EPOCH_CALENDAR_CONVERTER_ASSERT_SVH
`define EPOCH_CALENDAR_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ECC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("converter check failed");

// Next-cycle implication, sampled on clk, off during reset
`define ECC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("converter check failed");

`endif

// File: rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter package
// Payload types, controller/datapath interface structs and calendar constants.
// ----------------------------------------------------------------------------
package ecc_pkg;

    localparam int SECONDS_WIDTH = 32;
    localparam int REM_W         = 32;
    localparam int QUOT_W        = 16;
    localparam int DAYS_W        = 17;
    localparam int SUM_W         = 34;
    localparam int HMS_W         = 17;
    localparam int NUM_W         = 25;
    localparam int RECIP_W       = 26;
    localparam int PROD_W        = 51;

    localparam logic [11:0] BASE_YEAR = 12'd1970;
    // last year whose first day still lies inside a 32-bit seconds range
    localparam logic [11:0] MAX_YEAR  = 12'd2106;

    localparam logic [6:0] BASE_MOD100 = 7'd70;
    localparam logic [8:0] BASE_MOD400 = 9'd370;

    localparam logic [DAYS_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [HMS_W-1:0]  SECS_PER_HOUR = 17'd3600;
    localparam logic [HMS_W-1:0]  SECS_PER_MIN  = 17'd60;

    // ceil(2^k / d) for the odd part of each divisor: 675 (k 35), 225 (k 21), 15 (k 14)
    localparam logic [RECIP_W-1:0] RECIP_DAY  = 26'd50903317;
    localparam logic [RECIP_W-1:0] RECIP_HOUR = 26'd9321;
    localparam logic [RECIP_W-1:0] RECIP_MIN  = 26'd1093;

    localparam logic [SUM_W-1:0] MAX_SECONDS =
        SUM_W'((64'd1 << SECONDS_WIDTH) - 64'd1);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_DAY,
        ST_DIV_HOUR,
        ST_DIV_MIN,
        ST_YEAR,
        ST_MONTH,
        ST_MUL,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        req_type;
        logic [11:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
        logic [31:0] in_epoch;
    } req_t;

    typedef struct packed {
        logic [31:0] out_epoch;
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic        out_error;
    } rsp_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        div_sel_t div_sel;
        logic     year_step;
        logic     month_step;
        logic     add_day;
        logic     mul_step;
        logic     sum_step;
        logic     set_err;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic req_type;
        logic field_bad;
        logic div_last;
        logic year_done;
        logic month_done;
        logic day_bad;
        logic out_free;
    } status_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/ecc_ctrl.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter controller
// Sequences capture, division passes, year and month walks and result hand-off.
// ----------------------------------------------------------------------------
module ecc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  ecc_pkg::status_t status,
    output ecc_pkg::cmd_t    cmd
);
    import ecc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.div_sel = DIV_DAY;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (status.req_type)
                begin
                    state_next = ST_DIV_DAY;
                end
                else if (status.field_bad)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    state_next = ST_YEAR;
                end
            end
            ST_DIV_DAY:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_DAY;
                if (status.div_last)
                begin
                    state_next = ST_DIV_HOUR;
                end
            end
            ST_DIV_HOUR:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_HOUR;
                if (status.div_last)
                begin
                    state_next = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN:
            begin
                cmd.div_step = 1'b1;
                cmd.div_sel  = DIV_MIN;
                if (status.div_last)
                begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (status.year_done)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH:
            begin
                priority if (!status.month_done)
                begin
                    cmd.month_step = 1'b1;
                end
                else if (status.req_type)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.day_bad)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    cmd.add_day = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ecc_dp.sv
// ----------------------------------------------------------------------------
// Epoch calendar converter datapath
// Reciprocal constant divider, year/month walker, seconds accumulator, output
// register.
// ----------------------------------------------------------------------------
module ecc_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  ecc_pkg::req_t    req,
    input  ecc_pkg::cmd_t    cmd,
    output ecc_pkg::status_t status,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output ecc_pkg::rsp_t    rsp
);
    import ecc_pkg::*;

    req_t              req_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              phase_reg, phase_next;
    logic [DAYS_W-1:0] days_reg, days_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        min_reg, min_next;
    logic [11:0]       year_reg, year_next;
    logic [6:0]        mod100_reg, mod100_next;
    logic [8:0]        mod400_reg, mod400_next;
    logic [3:0]        month_reg, month_next;
    logic [SUM_W-1:0]  prod_reg, prod_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              err_reg, err_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic               leap;
    logic [8:0]         year_len;
    logic [4:0]         mon_len;
    logic [REM_W-1:0]   divisor;
    logic [NUM_W-1:0]   div_num;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  recip_prod;
    logic [QUOT_W-1:0]  quot_est;
    logic [HMS_W-1:0]   hms;
    logic               fwd_fail;

    assign leap = ((year_reg[1:0] == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mon_len  = month_len(month_reg, leap);

    // drop the power-of-two factor of the divisor, then multiply by the reciprocal of the rest
    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_DAY:
            begin
                divisor = REM_W'(SECS_PER_DAY);
                div_num = rem_reg[31:7];
                recip   = RECIP_DAY;
            end
            DIV_HOUR:
            begin
                divisor = REM_W'(SECS_PER_HOUR);
                div_num = NUM_W'(rem_reg[16:4]);
                recip   = RECIP_HOUR;
            end
            DIV_MIN:
            begin
                divisor = REM_W'(SECS_PER_MIN);
                div_num = NUM_W'(rem_reg[11:2]);
                recip   = RECIP_MIN;
            end
            default:
            begin
                divisor = REM_W'(SECS_PER_MIN);
                div_num = NUM_W'(rem_reg[11:2]);
                recip   = RECIP_MIN;
            end
        endcase
    end

    assign recip_prod = PROD_W'(div_num) * PROD_W'(recip);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_DAY:  quot_est = recip_prod[50:35];
            DIV_HOUR: quot_est = recip_prod[36:21];
            DIV_MIN:  quot_est = recip_prod[29:14];
            default:  quot_est = recip_prod[29:14];
        endcase
    end

    assign hms = HMS_W'(req_reg.in_hour) * SECS_PER_HOUR
               + HMS_W'(req_reg.in_minute) * SECS_PER_MIN
               + HMS_W'(req_reg.in_second);

    assign fwd_fail = err_reg || (sum_reg > MAX_SECONDS);

    always_comb
    begin
        status.req_type   = req_reg.req_type;
        status.field_bad  = (req_reg.in_year < BASE_YEAR) || (req_reg.in_year > MAX_YEAR)
                         || (req_reg.in_month == 4'd0) || (req_reg.in_month > MONTH_DEC)
                         || (req_reg.in_day == 5'd0) || (req_reg.in_hour > 5'd23)
                         || (req_reg.in_minute > 6'd59) || (req_reg.in_second > 6'd59);
        status.div_last   = phase_reg;
        status.year_done  = req_reg.req_type ? (days_reg < DAYS_W'(year_len))
                                             : (year_reg == req_reg.in_year);
        status.month_done = req_reg.req_type
                          ? ((month_reg == MONTH_DEC) || (days_reg < DAYS_W'(mon_len)))
                          : (month_reg == req_reg.in_month);
        status.day_bad    = req_reg.in_day > mon_len;
        status.out_free   = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        phase_next  = phase_reg;
        days_next   = days_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        year_next   = year_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next  = month_reg;
        prod_next   = prod_reg;
        sum_next    = sum_reg;
        err_next    = err_reg;

        if (cmd.load)
        begin
            rem_next    = req.in_epoch;
            quot_next   = '0;
            phase_next  = 1'b0;
            days_next   = '0;
            year_next   = BASE_YEAR;
            mod100_next = BASE_MOD100;
            mod400_next = BASE_MOD400;
            month_next  = MONTH_JAN;
            err_next    = 1'b0;
        end

        if (cmd.div_step)
        begin
            if (!phase_reg)
            begin
                quot_next  = quot_est;
                phase_next = 1'b1;
            end
            else
            begin
                // strip the whole units and park the quotient
                rem_next   = rem_reg - REM_W'(quot_reg) * divisor;
                phase_next = 1'b0;
                unique case (cmd.div_sel)
                    DIV_DAY:  days_next = DAYS_W'(quot_reg);
                    DIV_HOUR: hour_next = quot_reg[4:0];
                    DIV_MIN:  min_next  = quot_reg[5:0];
                    default:  min_next  = quot_reg[5:0];
                endcase
            end
        end

        if (cmd.year_step)
        begin
            days_next   = req_reg.req_type ? days_reg - DAYS_W'(year_len)
                                           : days_reg + DAYS_W'(year_len);
            year_next   = year_reg + 1'b1;
            mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 1'b1;
            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 1'b1;
        end

        if (cmd.month_step)
        begin
            days_next  = req_reg.req_type ? days_reg - DAYS_W'(mon_len)
                                          : days_reg + DAYS_W'(mon_len);
            month_next = month_reg + 1'b1;
        end

        if (cmd.add_day)
        begin
            days_next = days_reg + DAYS_W'(req_reg.in_day) - 1'b1;
        end

        if (cmd.mul_step)
        begin
            prod_next = SUM_W'(days_reg) * SUM_W'(SECS_PER_DAY);
        end

        if (cmd.sum_step)
        begin
            sum_next = prod_reg + SUM_W'(hms);
        end

        if (cmd.set_err)
        begin
            err_next = 1'b1;
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (req_reg.req_type)
        begin
            rsp_next.out_year   = year_reg;
            rsp_next.out_month  = month_reg;
            rsp_next.out_day    = 5'(days_reg + 1'b1);
            rsp_next.out_hour   = hour_reg;
            rsp_next.out_minute = min_reg;
            rsp_next.out_second = rem_reg[5:0];
        end
        else if (fwd_fail)
        begin
            rsp_next.out_error = 1'b1;
        end
        else
        begin
            rsp_next.out_epoch = sum_reg[31:0];
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        phase_reg  <= phase_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        year_reg   <= year_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg  <= month_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        err_reg    <= err_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/epoch_calendar_converter.sv
// Sequencing: calendar to epoch runs from the request transfer to rsp_valid through the
// year walk (up to 136 steps) and the month walk; epoch to calendar first runs the three
// divider passes (day, hour, minute), then the year and month walks.
// Throughput: one request at a time; the next transfer is taken the cycle after the result
// enters the output register, which may still be waiting on rsp_ready.
// Reset: rst_n clears the controller to idle and empties the output register.
// ----------------------------------------------------------------------------
// Epoch calendar converter
// Converts between Unix epoch seconds and Gregorian calendar fields.
// ----------------------------------------------------------------------------
`include "epoch_calendar_converter_assert.svh"

module epoch_calendar_converter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ecc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ecc_pkg::rsp_t rsp
);
    import ecc_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    rsp_clear;

    ecc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ecc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign rsp_clear = (rsp.out_epoch == '0) && (rsp.out_year == '0)
                    && (rsp.out_month == '0) && (rsp.out_day == '0)
                    && (rsp.out_hour == '0) && (rsp.out_minute == '0)
                    && (rsp.out_second == '0);

    `ECC_ASSERT_NEXT(a_busy_after_transfer, req_valid && req_ready, !req_ready)
    `ECC_ASSERT_NEXT(a_emit_presents_result, cmd.emit, rsp_valid)
    `ECC_ASSERT_IMPLY(a_error_zeroes_fields, rsp_valid && rsp.out_error, rsp_clear)
    `ECC_ASSERT_IMPLY(a_load_alone, cmd.load, !cmd.emit && !cmd.div_step && !cmd.year_step)

endmodule
